// File: design/hlu_pkg.sv
// Shared types, constants and arithmetic helpers for the Hankel LU solver.
`default_nettype none
package hlu_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 48;
    localparam int VAL_W         = 32;
    localparam int IDX_W         = 3;
    localparam int ORD_W         = 3;
    localparam int THR_W         = 16;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

    // Load kinds carried in op
    localparam logic OP_MOMENT = 1'b0;
    localparam logic OP_RHS    = 1'b1;

    // Result status codes
    localparam logic ST_SOLVED   = 1'b0;
    localparam logic ST_SINGULAR = 1'b1;

    localparam logic signed [ACC_W-1:0] S48_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S48_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One queued item handed from the front to the back
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic              start;
    } item_t;

    // Saturating 48-bit subtract
    function automatic logic signed [ACC_W-1:0] sub_sat(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] d;
        d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (d[ACC_W] != d[ACC_W-1]) begin
            return d[ACC_W] ? S48_MIN : S48_MAX;
        end
        return d[ACC_W-1:0];
    endfunction

    // Absolute value as unsigned magnitude
    function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage : hlu_pkg
`default_nettype wire

// File: design/hlu_mul.sv
// Multi-cycle 48x48 signed multiply with rounded shift and 48-bit saturation.
`default_nettype none
module hlu_mul (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [hlu_pkg::ACC_W-1:0] a,
    input  wire logic signed [hlu_pkg::ACC_W-1:0] b,
    input  wire logic [6:0]                      shift,
    output logic                                 done,
    output logic signed [hlu_pkg::ACC_W-1:0]     result
);
    import hlu_pkg::*;

    // Sign-magnitude, 24-bit digit pieces: four 24x24 partial products
    logic              neg_reg;
    logic [ACC_W-1:0]  ua_reg, ub_reg;
    logic [6:0]        sh_reg;
    logic [95:0]       prod_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;

    logic [23:0] pa, pb;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    logic [95:0] rnd;
    logic [95:0] shd;
    logic        ovf;
    logic [ACC_W-1:0] mag;

    always_comb begin
        pa    = step_reg[0] ? ua_reg[47:24] : ua_reg[23:0];
        pb    = step_reg[1] ? ub_reg[47:24] : ub_reg[23:0];
        pp    = pa * pb;
        pp_sh = {48'd0, pp} << (7'(24) * (7'(step_reg[0]) + 7'(step_reg[1])));
        rnd   = prod_reg + (96'd1 << (sh_reg - 7'd1));
        shd   = rnd >> sh_reg;
        ovf   = (shd[95:ACC_W] != '0);
        mag   = shd[ACC_W-1:0];
    end

    // Sequence four partial products, then round and saturate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end else begin
            if (start) begin
                done     <= 1'b0;
                busy_reg <= 1'b1;
                step_reg <= '0;
                neg_reg  <= a[ACC_W-1] ^ b[ACC_W-1];
                ua_reg   <= mag48(a);
                ub_reg   <= mag48(b);
                sh_reg   <= shift;
                prod_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg[2]) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    if (neg_reg) begin
                        result <= (ovf || mag > {1'b1, {(ACC_W-1){1'b0}}}) ? S48_MIN
                                  : -$signed(mag);
                    end else begin
                        result <= (ovf || mag[ACC_W-1]) ? S48_MAX : $signed(mag);
                    end
                end else begin
                    done     <= 1'b0;
                    prod_reg <= prod_reg + pp_sh;
                    step_reg <= step_reg + 3'd1;
                end
            end else begin
                done <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("multiplier done held");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !step_reg[2] |-> !start) else $error("multiplier restarted");
    a_done_after: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(busy_reg)) else $error("done without work");
`endif
endmodule : hlu_mul
`default_nettype wire

// File: design/hlu_recip.sv
// Bit-serial reciprocal 2^(3F)/d, rounded, saturated to 48 bits.
`default_nettype none
module hlu_recip #(
    parameter int FRAC_BITS = hlu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [hlu_pkg::ACC_W-1:0] d,
    output logic                                 done,
    output logic signed [hlu_pkg::ACC_W-1:0]     result
);
    import hlu_pkg::*;

    localparam int TOP = 3 * FRAC_BITS;
    localparam int CW  = $clog2(TOP + 2);

    logic              neg_reg, busy_reg;
    logic [ACC_W-1:0]  ud_reg;
    logic [ACC_W:0]    r_reg;
    logic [ACC_W:0]    q_reg;
    logic [CW-1:0]     i_reg;

    logic [ACC_W+1:0] r_sh;
    logic             ge;
    logic [ACC_W+1:0] r_new;
    logic [ACC_W+1:0] q_new;
    logic             ov;
    logic [ACC_W+1:0] q_rnd;

    always_comb begin
        r_sh  = {r_reg, (i_reg == CW'(TOP))};
        ge    = r_sh >= {2'b00, ud_reg};
        r_new = ge ? r_sh - {2'b00, ud_reg} : r_sh;
        q_new = {q_reg, ge};
        ov    = q_new > (ACC_W+2)'(2) ** (ACC_W-1);
        q_rnd = q_new + (ACC_W+2)'((r_new << 1) >= {1'b0, ud_reg});
    end

    // One quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            if (start) begin
                done     <= 1'b0;
                busy_reg <= 1'b1;
                neg_reg  <= d[ACC_W-1];
                ud_reg   <= mag48(d);
                r_reg    <= '0;
                q_reg    <= '0;
                i_reg    <= CW'(TOP);
            end else if (busy_reg) begin
                if (ov) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    result   <= neg_reg ? S48_MIN : S48_MAX;
                end else if (i_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    if (neg_reg) begin
                        result <= (q_rnd > (ACC_W+2)'(2) ** (ACC_W-1)) ? S48_MIN
                                  : -$signed(q_rnd[ACC_W-1:0]);
                    end else begin
                        result <= (q_rnd[ACC_W+1:ACC_W-1] != '0) ? S48_MAX
                                  : $signed(q_rnd[ACC_W-1:0]);
                    end
                end else begin
                    done  <= 1'b0;
                    r_reg <= r_new[ACC_W:0];
                    q_reg <= q_new[ACC_W:0];
                    i_reg <= i_reg - CW'(1);
                end
            end else begin
                done <= 1'b0;
            end
        end
    end
endmodule : hlu_recip
`default_nettype wire

// File: design/hlu_front.sv
// Front end: accepts items into a short queue for the solve engine.
`default_nettype none
module hlu_front #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire hlu_pkg::item_t  in_item,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output hlu_pkg::item_t       q_item
);
    import hlu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
            if (pop)  rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue overfilled");
    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
    a_cnt_dn: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 1'b1) else $error("count slip");
`endif
endmodule : hlu_front
`default_nettype wire

// File: design/hlu_back.sv
// Back end: stores loads and runs factorization and substitution sequences.
`default_nettype none
module hlu_back #(
    parameter int MAX_ORDER = hlu_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = hlu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire hlu_pkg::item_t              q_item,
    input  wire logic [hlu_pkg::ORD_W-1:0]   cfg_order,
    input  wire logic [hlu_pkg::THR_W-1:0]   cfg_thr,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [hlu_pkg::VAL_W-1:0]        out_value,
    output logic [1:0]                       out_row,
    output logic                             out_status,
    output logic                             out_last
);
    import hlu_pkg::*;

    localparam int MD = 2 * MAX_ORDER - 1;
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int MW = $clog2(MD + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_WAIT  = 8'b0000_1000,
        S_STORE = 8'b0001_0000,
        S_RECIP = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FAIL  = 8'b1000_0000
    } state_t;

    // Phases of one solve
    localparam logic [1:0] PH_LU = 2'd0;
    localparam logic [1:0] PH_FW = 2'd1;
    localparam logic [1:0] PH_BK = 2'd2;

    logic signed [ACC_W-1:0] mom_reg [MD];
    logic signed [ACC_W-1:0] rhs_reg [MAX_ORDER];
    logic signed [ACC_W-1:0] fac_reg [MAX_ORDER][MAX_ORDER];
    logic signed [ACC_W-1:0] rcp_reg [MAX_ORDER];
    logic signed [ACC_W-1:0] fwd_reg [MAX_ORDER];
    logic signed [ACC_W-1:0] x_reg   [MAX_ORDER];

    state_t                  state_reg;
    logic [1:0]              ph_reg;
    logic [NW-1:0]           n_reg, j_reg, k_reg, s_reg;
    logic                    fin_reg;   // last multiply of an element was the pivot scale
    logic signed [ACC_W-1:0] acc_reg;

    logic                    mul_go, mul_done, rcp_go, rcp_done;
    logic signed [ACC_W-1:0] mul_a, mul_b, mul_res, rcp_res;
    logic [6:0]              mul_sh;

    logic [NW-1:0] smax;
    logic          lower;
    logic [NW-1:0] jp1;
    logic [NW-1:0] nm1;
    logic          emit_load;

    hlu_mul u_mul (
        .aclk, .aresetn, .start(mul_go), .a(mul_a), .b(mul_b), .shift(mul_sh),
        .done(mul_done), .result(mul_res)
    );

    hlu_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .aclk, .aresetn, .start(rcp_go), .d(acc_reg), .done(rcp_done), .result(rcp_res)
    );

    assign q_ready   = (state_reg == S_IDLE);
    assign lower     = (k_reg < j_reg);
    assign smax      = lower ? k_reg : j_reg;
    assign jp1       = j_reg + NW'(1);
    assign nm1       = n_reg - NW'(1);
    assign emit_load = (state_reg == S_EMIT || state_reg == S_FAIL) && (!out_valid || out_ready);

    // Choose multiplier operands for the current step
    always_comb begin
        mul_a  = fac_reg[j_reg[NW-2:0]][s_reg[NW-2:0]];
        mul_b  = fac_reg[s_reg[NW-2:0]][k_reg[NW-2:0]];
        mul_sh = 7'(FRAC_BITS);
        mul_go = (state_reg == S_MUL);
        unique case (ph_reg)
            PH_FW: mul_b = fwd_reg[k_reg[NW-2:0]];
            PH_BK: mul_b = x_reg[k_reg[NW-2:0]];
            default: ;
        endcase
        if (ph_reg == PH_FW || ph_reg == PH_BK) begin
            mul_a = fac_reg[j_reg[NW-2:0]][k_reg[NW-2:0]];
        end
        if (fin_reg) begin
            mul_a  = acc_reg;
            mul_b  = rcp_reg[(ph_reg == PH_LU) ? k_reg[NW-2:0] : j_reg[NW-2:0]];
            mul_sh = 7'(2 * FRAC_BITS);
        end
    end

    assign rcp_go = (state_reg == S_RECIP) && !fin_reg;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            // Load a new result or drop the one just transferred
            if (emit_load)      out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        if (q_item.op == OP_MOMENT && 32'(q_item.index) < 32'(MD))
                            mom_reg[q_item.index[MW-1:0]] <= ACC_W'(signed'(q_item.value));
                        if (q_item.op == OP_RHS && 32'(q_item.index) < 32'(MAX_ORDER))
                            rhs_reg[q_item.index[NW-2:0]] <= ACC_W'(signed'(q_item.value));
                        if (q_item.start) begin
                            if (cfg_order == '0 || 32'(cfg_order) > 32'(MAX_ORDER)) begin
                                state_reg <= S_FAIL;
                            end else begin
                                n_reg     <= NW'(cfg_order);
                                ph_reg    <= PH_LU;
                                j_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= S_INIT;
                            end
                        end
                    end
                end
                S_INIT: begin
                    // Load the element's starting value
                    s_reg   <= '0;
                    fin_reg <= 1'b0;
                    unique case (ph_reg)
                        PH_LU:   acc_reg <= mom_reg[MW'(j_reg) + MW'(k_reg)];
                        PH_FW:   acc_reg <= rhs_reg[j_reg[NW-2:0]];
                        default: acc_reg <= fwd_reg[j_reg[NW-2:0]];
                    endcase
                    if (ph_reg == PH_BK) k_reg <= jp1;
                    if (ph_reg == PH_FW) k_reg <= '0;
                    state_reg <= S_STORE;
                end
                S_MUL: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (mul_done) begin
                        if (fin_reg) acc_reg <= mul_res;
                        else         acc_reg <= sub_sat(acc_reg, mul_res);
                        if (!fin_reg) begin
                            if (ph_reg == PH_LU) s_reg <= s_reg + NW'(1);
                            else                 k_reg <= k_reg + NW'(1);
                        end
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    // Either run another accumulate step or finish the element
                    priority if (ph_reg == PH_LU && !fin_reg && s_reg < smax) begin
                        state_reg <= S_MUL;
                    end else if (ph_reg == PH_FW && k_reg < j_reg) begin
                        state_reg <= S_MUL;
                    end else if (ph_reg == PH_BK && !fin_reg && k_reg < n_reg) begin
                        state_reg <= S_MUL;
                    end else if (!fin_reg && ((ph_reg == PH_LU && lower) || ph_reg == PH_BK))
                    begin
                        fin_reg   <= 1'b1;
                        state_reg <= S_MUL;
                    end else begin
                        fin_reg <= 1'b0;
                        unique case (ph_reg)
                            PH_LU: begin
                                fac_reg[j_reg[NW-2:0]][k_reg[NW-2:0]] <= acc_reg;
                                if (k_reg == j_reg && mag48(acc_reg) <= ACC_W'(cfg_thr))
                                    state_reg <= S_FAIL;
                                else if (k_reg == j_reg)
                                    state_reg <= S_RECIP;
                                else
                                    state_reg <= S_INIT;
                                if (k_reg == nm1) begin
                                    k_reg <= '0;
                                    if (jp1 == n_reg) begin
                                        ph_reg <= PH_FW;
                                        j_reg  <= '0;
                                    end else begin
                                        j_reg <= jp1;
                                    end
                                end else begin
                                    k_reg <= k_reg + NW'(1);
                                end
                            end
                            PH_FW: begin
                                fwd_reg[j_reg[NW-2:0]] <= acc_reg;
                                state_reg <= S_INIT;
                                if (jp1 == n_reg) begin
                                    ph_reg <= PH_BK;
                                    j_reg  <= nm1;
                                end else begin
                                    j_reg <= jp1;
                                end
                            end
                            default: begin
                                x_reg[j_reg[NW-2:0]] <= acc_reg;
                                if (j_reg == '0) begin
                                    state_reg <= S_EMIT;
                                end else begin
                                    state_reg <= S_INIT;
                                    j_reg     <= j_reg - NW'(1);
                                end
                            end
                        endcase
                    end
                end
                S_RECIP: begin
                    // Reciprocal unit is started on entry; fin_reg marks it running.
                    // The last pivot has already advanced the phase to forward.
                    if (rcp_done) begin
                        rcp_reg[(ph_reg == PH_LU) ? j_reg[NW-2:0] : nm1[NW-2:0]] <= rcp_res;
                        fin_reg   <= 1'b0;
                        state_reg <= S_INIT;
                    end else begin
                        fin_reg <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_load) begin
                        out_row    <= 2'(j_reg);
                        out_status <= ST_SOLVED;
                        out_last   <= (jp1 == n_reg);
                        if (x_reg[j_reg[NW-2:0]] > ACC_W'(32'sh7FFF_FFFF))
                            out_value <= 32'h7FFF_FFFF;
                        else if (x_reg[j_reg[NW-2:0]] < -ACC_W'(33'sh0_8000_0000))
                            out_value <= 32'h8000_0000;
                        else
                            out_value <= x_reg[j_reg[NW-2:0]][VAL_W-1:0];
                        j_reg <= jp1;
                        if (jp1 == n_reg) state_reg <= S_IDLE;
                    end
                end
                S_FAIL: begin
                    if (emit_load) begin
                        out_value  <= '0;
                        out_row    <= '0;
                        out_status <= ST_SINGULAR;
                        out_last   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_status == ST_SINGULAR |-> out_last) else $error("fail not last");
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_status == ST_SOLVED |-> 32'(out_row) < 32'(MAX_ORDER))
        else $error("row out of range");
`endif
endmodule : hlu_back
`default_nettype wire

// File: design/hankel_lu_linear_solve.sv
// Top level of the Hankel LU linear solver.
//
//  channel | direction | tdata (low bit up)              | tuser   | tlast
//  s_      | in        | index[2:0] value[34:3] (pad 40) | op      | start_solve
//  m_      | out       | solution_value[31:0] row[33:32] | status  | last
//  cfg     | in        | cfg_wdata: order / pivot_threshold by cfg_addr
//
// Loads take one item per cycle through a two-entry queue while the solve
// engine is idle. A solve runs on one shared multi-cycle multiplier and a
// bit-serial reciprocal. Reset is synchronous, active low; stores hold
// undefined data until written. The result register lets the queue fill
// while a result waits.
`default_nettype none
module hankel_lu_linear_solve #(
    parameter int MAX_ORDER = hlu_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = hlu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [39:0]                       s_tdata,  // index, value
    input  wire logic                              s_tuser,  // op
    input  wire logic                              s_tlast,  // start_solve
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [39:0]                            m_tdata,  // solution_value, row
    output logic                                   m_tuser,  // status
    output logic                                   m_tlast,  // last
    input  wire logic                              cfg_we,
    input  wire logic [hlu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [hlu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import hlu_pkg::*;

    logic [ORD_W-1:0] order_reg;
    logic [THR_W-1:0] thr_reg;
    item_t            in_item, q_item;
    logic             q_valid, q_ready;
    logic [VAL_W-1:0] out_value;
    logic [1:0]       out_row;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORD_W'(4);
            thr_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ORDER:     order_reg <= cfg_wdata[ORD_W-1:0];
                REG_THRESHOLD: thr_reg   <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.op    = s_tuser;
    assign in_item.index = s_tdata[2:0];
    assign in_item.value = s_tdata[34:3];
    assign in_item.start = s_tlast;

    hlu_front #(.DEPTH(2)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    hlu_back #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .cfg_order(order_reg), .cfg_thr(thr_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_value, .out_row,
        .out_status(m_tuser), .out_last(m_tlast)
    );

    assign m_tdata = {6'd0, out_row, out_value};
endmodule : hankel_lu_linear_solve
`default_nettype wire

// File: bench/tb_hankel_lu_linear_solve.sv
// Self-checking testbench for the Hankel LU linear solver: directed table, then random solves.
`default_nettype none
module tb_hankel_lu_linear_solve;
    timeunit 1ns;
    timeprecision 1ps;
    import hlu_pkg::*;

    localparam int  LIMIT        = 1_000_000;
    localparam int  NUM_ITEMS    = 280;
    localparam int  DRAIN_CYCLES = 100;
    localparam longint P47       = longint'(1) << 47;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [1:0]       row;
        logic             status;
        logic             last;
    } solution_t;

    typedef enum logic { ROW_LOAD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic             op;      // register index on configuration rows
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;   // register data on configuration rows
        logic             start;
        logic             singular; // expect a single singular-status result
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;   // index[2:0], value[34:3]
    logic s_tuser = 1'b0;        // op
    logic s_tlast = 1'b0;        // start_solve
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;        // solution_value[31:0], row[33:32]
    logic m_tuser;               // status
    logic m_tlast;               // last
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state
    longint moments [0:6];
    longint rhs_vals [0:3];
    longint lu [0:15];
    longint pivot_inv [0:3];
    longint fwd [0:3];
    int     cur_order = 4;
    longint cur_thr = 0;

    solution_t expected_solutions[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 0;
    int  items_sent = 0;

    hankel_lu_linear_solve u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the result side in random bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        solution_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_solutions.size() == 0) begin
                $error("unexpected result transfer: value %h", m_tdata[31:0]);
                errors++;
            end else begin
                e = expected_solutions.pop_front();
                if (m_tdata[31:0] !== e.value) begin
                    $error("solution_value: expected %h, got %h", e.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[33:32] !== e.row) begin
                    $error("row: expected %0d, got %0d", e.row, m_tdata[33:32]);
                    errors++;
                end
                if (m_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Signed saturation of a magnitude to 48 bits
    function automatic longint sat_mag(bit neg, logic [97:0] m);
        if (neg) return (m > 98'(P47)) ? -P47 : -longint'(m);
        return (m > 98'(P47 - 1)) ? P47 - 1 : longint'(m);
    endfunction

    function automatic longint sub48(longint a, longint b);
        longint d;
        d = a - b;
        if (d > P47 - 1) return P47 - 1;
        if (d < -P47) return -P47;
        return d;
    endfunction

    // Exact product, shifted with round-half-away, saturated to 48 bits
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [97:0] ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 98'(-a) : 98'(a);
        mb = (b < 0) ? 98'(-b) : 98'(b);
        p = ma * mb;
        p = (p + (98'd1 << (sh - 1))) >> sh;
        return sat_mag(neg, p);
    endfunction

    // 2^48 / d rounded, saturated
    function automatic longint recip48(longint d);
        logic [63:0] ud, q, r;
        ud = (d < 0) ? 64'(-d) : 64'(d);
        if (ud == 0) return 0;
        q = (64'd1 << 48) / ud;
        r = (64'd1 << 48) % ud;
        if (q <= 64'(P47) && 2 * r >= ud) q++;
        return sat_mag(d < 0, 98'(q));
    endfunction

    function automatic void push_solution(longint v, int row, logic st, logic lst);
        solution_t s;
        s.value = v[31:0];
        s.row = row[1:0];
        s.status = st;
        s.last = lst;
        expected_solutions.push_back(s);
    endfunction

    // Factor, substitute, and queue the expected solution values
    function automatic void predict_solve();
        int n, j, k, s, smax;
        longint acc, v;
        longint x [0:3];
        bit lower;
        n = cur_order;
        if (n < 1 || n > 4) begin
            push_solution(0, 0, ST_SINGULAR, 1'b1);
            return;
        end
        for (j = 0; j < n; j++) begin
            for (k = 0; k < n; k++) begin
                lower = k < j;
                smax = lower ? k : j;
                acc = moments[j + k];
                for (s = 0; s < smax; s++)
                    acc = sub48(acc, mul_round(lu[j*4+s], lu[s*4+k], FRAC_BITS_DEF));
                if (lower) begin
                    lu[j*4+k] = mul_round(acc, pivot_inv[k], 2 * FRAC_BITS_DEF);
                end else begin
                    lu[j*4+k] = acc;
                    if (k == j) begin
                        if (((acc < 0) ? -acc : acc) <= cur_thr) begin
                            push_solution(0, 0, ST_SINGULAR, 1'b1);
                            return;
                        end
                        pivot_inv[j] = recip48(acc);
                    end
                end
            end
        end
        for (j = 0; j < n; j++) begin
            acc = rhs_vals[j];
            for (k = 0; k < j; k++)
                acc = sub48(acc, mul_round(lu[j*4+k], fwd[k], FRAC_BITS_DEF));
            fwd[j] = acc;
        end
        for (j = n - 1; j >= 0; j--) begin
            acc = fwd[j];
            for (k = j + 1; k < n; k++)
                acc = sub48(acc, mul_round(lu[j*4+k], x[k], FRAC_BITS_DEF));
            x[j] = mul_round(acc, pivot_inv[j], 2 * FRAC_BITS_DEF);
        end
        for (j = 0; j < n; j++) begin
            v = x[j];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            push_solution(v, j, ST_SOLVED, j == n - 1);
        end
    endfunction

    // Drive one item, wait for its transfer, then update the prediction
    task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic start, logic typed_singular);
        int pending;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, val, idx};
        s_tuser <= op;
        s_tlast <= start;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == OP_MOMENT && idx < 7) moments[idx] = longint'($signed(val));
        if (op == OP_RHS && idx < 4) rhs_vals[idx] = longint'($signed(val));
        if (start) begin
            pending = expected_solutions.size();
            predict_solve();
            if (typed_singular) begin
                while (expected_solutions.size() > pending) void'(expected_solutions.pop_back());
                push_solution(0, 0, ST_SINGULAR, 1'b1);
            end
        end
    endtask

    // Write a register once everything in flight has drained
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (expected_solutions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_ORDER) cur_order = int'(data[ORD_W-1:0]);
        else cur_thr = longint'(data);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 32'h1FFF)) - 32'sh1000);
            default: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
        endcase
    endfunction

    // One well-formed load sequence in shuffled order, closed by a start
    task automatic random_solve();
        int n, cnt, i, j;
        logic       ops [0:10];
        logic [2:0] idxs [0:10];
        logic       to;
        logic [2:0] ti;
        n = (cur_order >= 1 && cur_order <= 4) ? cur_order : $urandom_range(1, 4);
        cnt = 0;
        for (i = 0; i < 2 * n - 1; i++) begin
            ops[cnt] = OP_MOMENT; idxs[cnt] = 3'(i); cnt++;
        end
        for (i = 0; i < n; i++) begin
            ops[cnt] = OP_RHS; idxs[cnt] = 3'(i); cnt++;
        end
        for (i = cnt - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            to = ops[i]; ops[i] = ops[j]; ops[j] = to;
            ti = idxs[i]; idxs[i] = idxs[j]; idxs[j] = ti;
        end
        for (i = 0; i < cnt; i++) begin
            // Occasional noise: an ignored load or an early start
            if ($urandom_range(0, 19) == 0)
                send_item(OP_MOMENT, 3'd7, $urandom(), 1'b0, 1'b0);
            if ($urandom_range(0, 19) == 0)
                send_item(OP_RHS, 3'($urandom_range(4, 7)), $urandom(),
                          1'($urandom_range(0, 1)), 1'b0);
            send_item(ops[i], idxs[i], rand_value(), i == cnt - 1, 1'b0);
        end
    endtask

    stim_row_t directed [$];

    task automatic add_row(row_kind_t kind, logic op, int idx, logic [31:0] val,
                           logic start, logic sing);
        stim_row_t r;
        r.kind = kind; r.op = op; r.index = idx[2:0]; r.value = val;
        r.start = start; r.singular = sing;
        directed.push_back(r);
    endtask

    initial begin
        int i;
        logic [CFG_DATA_W-1:0] thr;

        // All-zero order-4 system with extreme right-hand values: zero pivot
        for (i = 0; i < 7; i++) add_row(ROW_LOAD, OP_MOMENT, i, 32'h0, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 1, 32'h8000_0000, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 2, 32'h0000_0001, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 3, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Nonsingular diagonal-heavy system with extreme moments, ignored loads
        add_row(ROW_LOAD, OP_MOMENT, 0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 2, 32'h0001_0000, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 4, 32'h8000_0000, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 6, 32'h0002_0000, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 7, 32'h1234_5678, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 5, 32'hDEAD_BEEF, 1'b1, 1'b0);
        // Order 1 with the largest threshold: at and just above it
        add_row(ROW_CFG, REG_ORDER, 0, 32'd1, 1'b0, 1'b0);
        add_row(ROW_CFG, REG_THRESHOLD, 0, 32'hFFFF, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 0, 32'h0000_FFFF, 1'b1, 1'b1);
        add_row(ROW_LOAD, OP_MOMENT, 0, 32'h8000_0000, 1'b1, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 0, 32'hFFFF_0000, 1'b1, 1'b0);
        // Bad orders
        add_row(ROW_CFG, REG_ORDER, 0, 32'd0, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 7, 32'h0, 1'b1, 1'b1);
        add_row(ROW_CFG, REG_ORDER, 0, 32'd7, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_MOMENT, 1, 32'h0003_0000, 1'b1, 1'b1);
        add_row(ROW_CFG, REG_THRESHOLD, 0, 32'h0, 1'b0, 1'b0);
        add_row(ROW_CFG, REG_ORDER, 0, 32'd4, 1'b0, 1'b0);
        add_row(ROW_LOAD, OP_RHS, 2, 32'h0001_8000, 1'b1, 1'b0);

        for (i = 0; i < 7; i++) moments[i] = 0;
        for (i = 0; i < 4; i++) begin
            rhs_vals[i] = 0; pivot_inv[i] = 0; fwd[i] = 0;
        end
        for (i = 0; i < 16; i++) lu[i] = 0;

        // Hold reset, then release it once
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG)
                write_reg(directed[r].op, directed[r].value[CFG_DATA_W-1:0]);
            else
                send_item(directed[r].op, directed[r].index, directed[r].value,
                          directed[r].start, directed[r].singular);
        end

        // Random solves, with a new setting every few solves
        while (items_sent < NUM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 7))
                    0: write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(0, 7)));
                    1: write_reg(REG_ORDER, CFG_DATA_W'(4));
                    default: write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(1, 4)));
                endcase
                case ($urandom_range(0, 3))
                    0: thr = 16'h0;
                    1: thr = 16'hFFFF;
                    2: thr = 16'($urandom_range(0, 255));
                    default: thr = 16'($urandom());
                endcase
                write_reg(REG_THRESHOLD, thr);
            end
            if (items_sent > NUM_ITEMS - 40) quiet = 1;
            random_solve();
        end
        s_tvalid <= 1'b0;

        // Drain and finish
        while (expected_solutions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
